// ===== hw/rtl/srip_pkg.sv =====
package srip_pkg;

    // Result status codes.
    localparam logic [1:0] ST_SUCCESS = 2'd0;
    localparam logic [1:0] ST_END     = 2'd1;
    localparam logic [1:0] ST_CHAR    = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // Radix selection codes.
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_OCT = 2'd2;
    localparam logic [1:0] RADIX_BIN = 2'd3;

    // Digit value given to a byte that is no digit in any radix.
    localparam logic [5:0] DIGIT_NONE = 6'd63;

    // Largest magnitude a token may reach (two to the power 63).
    localparam logic [63:0] MAG_LIMIT = 64'h8000_0000_0000_0000;

    // Classification of one text byte.
    typedef struct packed {
        logic       is_space;
        logic       is_minus;
        logic       is_zero;
        logic       is_x;
        logic       is_o;
        logic       is_b;
        logic [5:0] digit;
    } t_char_info;

    // Outcome of folding one digit into the magnitude.
    typedef struct packed {
        logic        bad_digit;
        logic        overflow;
        logic [63:0] next_acc;
    } t_acc_res;

endpackage

// ===== hw/rtl/srip_in_if.sv =====
interface srip_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       end_of_text;

    modport source (output valid, output char_code, output end_of_text, input ready);
    modport sink (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== hw/rtl/srip_out_if.sv =====
interface srip_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic signed [63:0] value;

    modport source (output valid, output status, output value, input ready);
    modport sink (input valid, input status, input value, output ready);
endinterface

// ===== hw/rtl/srip_char_class.sv =====
module srip_char_class (
    input  logic [7:0]          i_char,
    output srip_pkg::t_char_info o_info
);
    import srip_pkg::*;

    // Whitespace, sign and prefix letters.
    assign o_info.is_space = (i_char == 8'h20) || ((i_char >= 8'h09) && (i_char <= 8'h0D));
    assign o_info.is_minus = (i_char == 8'h2D);
    assign o_info.is_zero  = (i_char == 8'h30);
    assign o_info.is_x     = (i_char == 8'h78);
    assign o_info.is_o     = (i_char == 8'h6F);
    assign o_info.is_b     = (i_char == 8'h62);

    // Digit value: 0-9, then letters of either case for 10 to 35.
    always_comb begin
        if ((i_char >= 8'h30) && (i_char <= 8'h39)) begin
            o_info.digit = 6'(i_char - 8'h30);
        end else if ((i_char >= 8'h41) && (i_char <= 8'h5A)) begin
            o_info.digit = 6'(i_char - 8'd55);
        end else if ((i_char >= 8'h61) && (i_char <= 8'h7A)) begin
            o_info.digit = 6'(i_char - 8'd87);
        end else begin
            o_info.digit = DIGIT_NONE;
        end
    end

endmodule

// ===== hw/rtl/srip_accum.sv =====
module srip_accum (
    input  logic [63:0]        i_acc,
    input  logic [1:0]         i_radix,
    input  logic [5:0]         i_digit,
    output srip_pkg::t_acc_res o_res
);
    import srip_pkg::*;

    logic [68:0] acc_w;
    logic [68:0] prod;
    logic [68:0] sum;
    logic [6:0]  radix_val;

    assign acc_w = {5'd0, i_acc};

    // Multiply by the radix with shifts; decimal is eight times plus two times.
    always_comb begin
        unique case (i_radix)
            RADIX_HEX: begin
                prod      = acc_w << 4;
                radix_val = 7'd16;
            end
            RADIX_OCT: begin
                prod      = acc_w << 3;
                radix_val = 7'd8;
            end
            RADIX_BIN: begin
                prod      = acc_w << 1;
                radix_val = 7'd2;
            end
            default: begin
                prod      = (acc_w << 3) + (acc_w << 1);
                radix_val = 7'd10;
            end
        endcase
    end

    // The exact sum cannot wrap in 69 bits, so one compare catches overflow.
    assign sum             = prod + {63'd0, i_digit};
    assign o_res.bad_digit = {1'b0, i_digit} >= radix_val;
    assign o_res.overflow  = sum > {5'd0, MAG_LIMIT};
    assign o_res.next_acc  = sum[63:0];

endmodule

// ===== hw/rtl/signed_radix_integer_parser.sv =====
// A byte is held in the input stage register, and its result in the result register.
// Throughput: one text byte per cycle while the result stage is not stalled.
// Rate is set by the single shift-add and compare that folds a digit in.
// Reset (synchronous, active low) empties both register stages and returns the
// parser to skipping whitespace with a cleared sign, radix and magnitude.
module signed_radix_integer_parser (
    input logic        i_clk,
    input logic        i_rst_n,
    srip_in_if.sink    i_in,
    srip_out_if.source o_out
);
    import srip_pkg::*;

    localparam logic [2:0] PH_SKIP    = 3'd0;
    localparam logic [2:0] PH_SIGN    = 3'd1;
    localparam logic [2:0] PH_ZERO    = 3'd2;
    localparam logic [2:0] PH_PREFIX  = 3'd3;
    localparam logic [2:0] PH_DIGITS  = 3'd4;
    localparam logic [2:0] PH_DISCARD = 3'd5;

    // Input stage.
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_eot;

    // Token state.
    logic [2:0]  r_phase;
    logic [2:0]  n_phase;
    logic        r_neg;
    logic        n_neg;
    logic [1:0]  r_radix;
    logic [1:0]  n_radix;
    logic [63:0] r_acc;
    logic [63:0] n_acc;

    // Result stage.
    logic        r_out_valid;
    logic [1:0]  r_out_status;
    logic [63:0] r_out_value;

    logic        adv;
    logic        emit;
    logic [1:0]  res_status;
    logic [63:0] res_value;
    logic        sep;
    logic [2:0]  ph;
    logic [63:0] acc_src;
    logic [1:0]  radix_src;
    t_char_info  info;
    t_acc_res    dres;

    // The result stage moves on when it is empty or being drained.
    assign adv        = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_in_valid || adv;

    srip_char_class u_class (
        .i_char (r_in_char),
        .o_info (info)
    );

    // A new token starts from a cleared magnitude in decimal.
    assign acc_src   = (ph == PH_SKIP) ? 64'd0 : r_acc;
    assign radix_src = (ph == PH_SKIP) ? RADIX_DEC : r_radix;

    srip_accum u_accum (
        .i_acc   (acc_src),
        .i_radix (radix_src),
        .i_digit (info.digit),
        .o_res   (dres)
    );

    assign sep = r_in_eot || info.is_space;
    assign ph  = (r_phase > PH_DISCARD) ? PH_SKIP : r_phase;

    // Next token state and result for the byte in the input stage.
    always_comb begin
        logic take;
        take       = 1'b0;
        n_phase    = r_phase;
        n_neg      = r_neg;
        n_radix    = r_radix;
        n_acc      = r_acc;
        emit       = 1'b0;
        res_status = ST_SUCCESS;
        res_value  = 64'd0;

        unique case (ph)
            PH_SKIP: begin
                if (r_in_eot) begin
                    emit       = 1'b1;
                    res_status = ST_END;
                end else if (!info.is_space) begin
                    n_neg   = info.is_minus;
                    n_radix = RADIX_DEC;
                    n_acc   = 64'd0;
                    if (info.is_minus) begin
                        n_phase = PH_SIGN;
                    end else if (info.is_zero) begin
                        n_phase = PH_ZERO;
                    end else begin
                        take = 1'b1;
                    end
                end
            end
            PH_SIGN, PH_PREFIX: begin
                if (sep) begin
                    emit       = 1'b1;
                    res_status = ST_CHAR;
                    n_phase    = PH_SKIP;
                end else if ((ph == PH_SIGN) && info.is_zero) begin
                    n_phase = PH_ZERO;
                end else begin
                    take = 1'b1;
                end
            end
            PH_ZERO: begin
                if (sep) begin
                    emit    = 1'b1;
                    n_phase = PH_SKIP;
                end else if (info.is_x) begin
                    n_radix = RADIX_HEX;
                    n_phase = PH_PREFIX;
                end else if (info.is_o) begin
                    n_radix = RADIX_OCT;
                    n_phase = PH_PREFIX;
                end else if (info.is_b) begin
                    n_radix = RADIX_BIN;
                    n_phase = PH_PREFIX;
                end else begin
                    take = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (sep) begin
                    emit    = 1'b1;
                    n_phase = PH_SKIP;
                    if (r_neg) begin
                        res_value = 64'd0 - r_acc;
                    end else if (r_acc[63]) begin
                        res_status = ST_RANGE;
                    end else begin
                        res_value = r_acc;
                    end
                end else begin
                    take = 1'b1;
                end
            end
            default: begin
                if (sep) begin
                    n_phase = PH_SKIP;
                end
            end
        endcase

        // Fold in a digit, or report a bad digit or an overflow.
        if (take) begin
            if (dres.bad_digit) begin
                emit       = 1'b1;
                res_status = ST_CHAR;
                n_phase    = PH_DISCARD;
            end else if (dres.overflow) begin
                emit       = 1'b1;
                res_status = ST_RANGE;
                n_phase    = PH_DISCARD;
            end else begin
                n_acc   = dres.next_acc;
                n_phase = PH_DIGITS;
            end
        end

        // The end of the text always starts a fresh text.
        if (r_in_eot) begin
            n_phase = PH_SKIP;
        end
    end

    // Input stage register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_char <= i_in.char_code;
            r_in_eot  <= i_in.end_of_text;
        end
    end

    // Token state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_SKIP;
            r_neg       <= 1'b0;
            r_radix     <= RADIX_DEC;
            r_acc       <= 64'd0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_in_valid && emit;
            if (r_in_valid) begin
                r_phase <= n_phase;
                r_neg   <= n_neg;
                r_radix <= n_radix;
                r_acc   <= n_acc;
            end
        end
        if (adv && r_in_valid && emit) begin
            r_out_status <= res_status;
            r_out_value  <= res_value;
        end
    end

    assign o_out.valid  = r_out_valid;
    assign o_out.status = r_out_status;
    assign o_out.value  = r_out_value;

    // The magnitude never exceeds two to the power 63.
    a_acc_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= MAG_LIMIT)
        else $error("magnitude above limit");

    // A result with any status other than success carries a zero value.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status != ST_SUCCESS)) |-> (r_out_value == 64'd0))
        else $error("error result with non-zero value");

    // After an end of text has been consumed, the parser skips whitespace.
    a_eot_skip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_in_valid && r_in_eot) |=> (r_phase == PH_SKIP))
        else $error("end of text did not restart parsing");

    // A full input stage behind a stalled result takes no new word.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_out_valid && !o_out.ready) |-> !i_in.ready)
        else $error("input taken while stalled");

endmodule

// ===== dv/signed_radix_integer_parser_test.sv =====
`timescale 1ns / 100ps

module signed_radix_integer_parser_test;

    import srip_pkg::*;

    // Parser phases, mirrored for the expected-result calculation.
    typedef enum logic [2:0] {
        P_SKIP,
        P_SIGN,
        P_ZERO,
        P_PREFIX,
        P_DIGITS,
        P_DISCARD
    } parse_phase_e;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [63:0] value;
    } parse_result_t;

    // One input word, optionally with its result written out by hand.
    typedef struct packed {
        logic [7:0]  chr;
        logic        eot;
        logic        typed;
        logic        has_res;
        logic [1:0]  status;
        logic [63:0] value;
    } stim_row_t;

    localparam logic TYPED     = 1'b1;
    localparam logic PREDICTED = 1'b0;

    localparam logic [7:0] CH_MINUS = "-";
    localparam logic [7:0] CH_ZERO  = "0";
    localparam logic [7:0] CH_X     = "x";
    localparam logic [7:0] CH_O     = "o";
    localparam logic [7:0] CH_B     = "b";
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_VT    = 8'h0B;
    localparam logic [7:0] CH_FF    = 8'h0C;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam logic [7:0] BLANKS [6] = '{CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR};
    localparam logic [7:0] PREFIXES [6] = '{"x", "o", "b", "X", "O", "B"};

    // Idle percentages of the sender and the receiver in each random phase.
    localparam int GAP_PCT   [4] = '{0, 61, 0, 9};
    localparam int STALL_PCT [4] = '{0, 0, 61, 9};
    localparam int WORDS_PER_PHASE = 400;

    // Directed words: chr, eot, typed, has_res, status, value.
    localparam stim_row_t DIRECTED [26] = '{
        '{8'h00,    1'b1, TYPED, 1'b1, ST_END,     64'd0},
        '{CH_SPACE, 1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_MINUS, 1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{8'h00,    1'b1, TYPED, 1'b1, ST_CHAR,    64'd0},
        '{CH_ZERO,  1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_TAB,   1'b0, TYPED, 1'b1, ST_SUCCESS, 64'd0},
        '{CH_ZERO,  1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_X,     1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_LF,    1'b0, TYPED, 1'b1, ST_CHAR,    64'd0},
        '{CH_ZERO,  1'b0, PREDICTED, 1'b0, ST_SUCCESS, 64'd0},
        '{"7",      1'b0, PREDICTED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_SPACE, 1'b0, PREDICTED, 1'b0, ST_SUCCESS, 64'd0},
        '{8'h00,    1'b0, TYPED, 1'b1, ST_CHAR,    64'd0},
        '{8'hFF,    1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_VT,    1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_MINUS, 1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_ZERO,  1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_B,     1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{"1",      1'b0, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{"2",      1'b0, TYPED, 1'b1, ST_CHAR,    64'd0},
        '{8'hFF,    1'b1, TYPED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_ZERO,  1'b0, PREDICTED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_X,     1'b0, PREDICTED, 1'b0, ST_SUCCESS, 64'd0},
        '{"a",      1'b0, PREDICTED, 1'b0, ST_SUCCESS, 64'd0},
        '{"F",      1'b0, PREDICTED, 1'b0, ST_SUCCESS, 64'd0},
        '{CH_CR,    1'b0, PREDICTED, 1'b0, ST_SUCCESS, 64'd0}
    };

    logic i_clk;
    logic i_rst_n;

    srip_in_if  word_in ();
    srip_out_if result_out ();

    signed_radix_integer_parser i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (word_in),
        .o_out   (result_out)
    );

    // Token state of the expected-result calculation.
    parse_phase_e tok_phase;
    logic         tok_negative;
    logic [1:0]   tok_radix;
    logic [63:0]  tok_magnitude;

    parse_result_t pending_results [$];
    stim_row_t     text_q [$];

    int error_count = 0;
    int words_sent  = 0;
    int gap_pct     = 0;
    int stall_pct   = 0;

    // Free-running clock, 10 ns period.
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic logic is_blank(input logic [7:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic [4:0] radix_value(input logic [1:0] code);
        case (code)
            RADIX_HEX: return 5'd16;
            RADIX_OCT: return 5'd8;
            RADIX_BIN: return 5'd2;
            default:   return 5'd10;
        endcase
    endfunction

    function automatic logic [5:0] digit_value(input logic [7:0] c);
        logic [7:0] t;
        if (c >= "0" && c <= "9") begin
            t = c - 8'h30;
        end else if (c >= "A" && c <= "Z") begin
            t = c - 8'h37;
        end else if (c >= "a" && c <= "z") begin
            t = c - 8'h57;
        end else begin
            t = {2'b00, DIGIT_NONE};
        end
        return t[5:0];
    endfunction

    // Text character for a digit value, letters in a random case.
    function automatic logic [7:0] digit_char(input logic [5:0] d);
        logic [7:0] t;
        t = {2'b00, d};
        if (t < 8'd10) begin
            return CH_ZERO + t;
        end
        if ($urandom_range(1) == 0) begin
            return 8'h57 + t;
        end
        return 8'h37 + t;
    endfunction

    // Folds one byte into the magnitude; returns 1 when it ends in an error.
    function automatic logic fold_digit(input logic [7:0] c, output parse_result_t r);
        logic [71:0] d72;
        logic [71:0] base;
        logic [71:0] wide;
        r    = '{ST_SUCCESS, 64'sd0};
        d72  = {66'd0, digit_value(c)};
        base = {67'd0, radix_value(tok_radix)};
        if (d72 >= base) begin
            tok_phase = P_DISCARD;
            r.status  = ST_CHAR;
            return 1'b1;
        end
        wide = {8'd0, tok_magnitude} * base + d72;
        if (wide > {8'd0, MAG_LIMIT}) begin
            tok_phase = P_DISCARD;
            r.status  = ST_RANGE;
            return 1'b1;
        end
        tok_magnitude = wide[63:0];
        tok_phase     = P_DIGITS;
        return 1'b0;
    endfunction

    // Advances the token state by one word; returns 1 when a result is due.
    function automatic logic parse_word(input logic [7:0] c, input logic eot,
                                        output parse_result_t r);
        logic         sep;
        logic         got;
        parse_phase_e now;
        sep = eot || is_blank(c);
        got = 1'b0;
        r   = '{ST_SUCCESS, 64'sd0};
        now = tok_phase;
        case (now)
            P_SKIP: begin
                if (eot) begin
                    got      = 1'b1;
                    r.status = ST_END;
                end else if (!is_blank(c)) begin
                    tok_negative  = 1'b0;
                    tok_radix     = RADIX_DEC;
                    tok_magnitude = 64'd0;
                    if (c == CH_MINUS) begin
                        tok_negative = 1'b1;
                        tok_phase    = P_SIGN;
                    end else if (c == CH_ZERO) begin
                        tok_phase = P_ZERO;
                    end else begin
                        got = fold_digit(c, r);
                    end
                end
            end
            P_SIGN, P_PREFIX: begin
                if (sep) begin
                    got       = 1'b1;
                    r.status  = ST_CHAR;
                    tok_phase = P_SKIP;
                end else if (now == P_SIGN && c == CH_ZERO) begin
                    tok_phase = P_ZERO;
                end else begin
                    got = fold_digit(c, r);
                end
            end
            P_ZERO: begin
                if (sep) begin
                    got       = 1'b1;
                    tok_phase = P_SKIP;
                end else if (c == CH_X) begin
                    tok_radix = RADIX_HEX;
                    tok_phase = P_PREFIX;
                end else if (c == CH_O) begin
                    tok_radix = RADIX_OCT;
                    tok_phase = P_PREFIX;
                end else if (c == CH_B) begin
                    tok_radix = RADIX_BIN;
                    tok_phase = P_PREFIX;
                end else begin
                    got = fold_digit(c, r);
                end
            end
            P_DIGITS: begin
                if (sep) begin
                    got = 1'b1;
                    if (tok_negative) begin
                        r.value = 64'd0 - tok_magnitude;
                    end else if (tok_magnitude >= MAG_LIMIT) begin
                        r.status = ST_RANGE;
                    end else begin
                        r.value = tok_magnitude;
                    end
                    tok_phase = P_SKIP;
                end else begin
                    got = fold_digit(c, r);
                end
            end
            default: begin
                if (sep) begin
                    tok_phase = P_SKIP;
                end
            end
        endcase
        // Every end of text starts a fresh text.
        if (eot) begin
            tok_phase = P_SKIP;
        end
        return got;
    endfunction

    function automatic stim_row_t text_word(input logic [7:0] c);
        return '{c, 1'b0, PREDICTED, 1'b0, ST_SUCCESS, 64'd0};
    endfunction

    // Whitespace mostly, now and then an end of text with a random byte.
    function automatic stim_row_t separator_word();
        if ($urandom_range(7) == 0) begin
            return '{8'($urandom_range(255)), 1'b1, PREDICTED, 1'b0, ST_SUCCESS, 64'd0};
        end
        return text_word(BLANKS[$urandom_range(5)]);
    endfunction

    // Queues one token: mostly well formed, the rest noise and broken tokens.
    task automatic build_token();
        logic [63:0] mag;
        logic [63:0] v;
        logic [63:0] base64;
        logic [63:0] rem;
        logic [1:0]  rc;
        logic [7:0]  digs [$];
        int          n;
        if ($urandom_range(3) == 0) begin
            text_q.push_back(text_word(BLANKS[$urandom_range(5)]));
        end
        if ($urandom_range(99) < 80) begin
            if ($urandom_range(1) == 1) begin
                text_q.push_back(text_word(CH_MINUS));
            end
            rc = 2'($urandom_range(3));
            case ($urandom_range(9))
                0, 1, 2, 3: mag = 64'($urandom_range(1000));
                4, 5:       mag = {$urandom, $urandom} >> $urandom_range(63);
                6, 7: begin
                    // Values at the edges of the signed range.
                    case ($urandom_range(5))
                        0:       mag = 64'd0;
                        1:       mag = 64'd1;
                        2:       mag = MAG_LIMIT - 64'd1;
                        3:       mag = MAG_LIMIT;
                        4:       mag = MAG_LIMIT + 64'd1;
                        default: mag = '1;
                    endcase
                end
                default: mag = 64'($urandom);
            endcase
            if (rc != RADIX_DEC) begin
                text_q.push_back(text_word(CH_ZERO));
                case (rc)
                    RADIX_HEX: text_q.push_back(text_word(CH_X));
                    RADIX_OCT: text_q.push_back(text_word(CH_O));
                    default:   text_q.push_back(text_word(CH_B));
                endcase
            end
            if ($urandom_range(7) == 0) begin
                text_q.push_back(text_word(CH_ZERO));
            end
            base64 = {59'd0, radix_value(rc)};
            v = mag;
            do begin
                rem = v % base64;
                digs.push_front(digit_char(rem[5:0]));
                v = v / base64;
            end while (v != 64'd0);
            foreach (digs[i]) begin
                text_q.push_back(text_word(digs[i]));
            end
            // An extra digit pushes large values past the limit.
            if ($urandom_range(9) == 0) begin
                text_q.push_back(text_word(digit_char(6'($urandom_range(radix_value(rc) - 1)))));
            end
        end else begin
            case ($urandom_range(4))
                0: begin
                    n = $urandom_range(4, 1);
                    repeat (n) text_q.push_back(text_word(8'($urandom_range(255))));
                end
                1: text_q.push_back(text_word(CH_MINUS));
                2: begin
                    text_q.push_back(text_word(CH_ZERO));
                    text_q.push_back(text_word(PREFIXES[$urandom_range(5)]));
                end
                3: begin
                    text_q.push_back(text_word(8'("1" + $urandom_range(8))));
                    text_q.push_back(text_word(8'($urandom_range(255))));
                end
                default: begin
                end
            endcase
        end
        text_q.push_back(separator_word());
    endtask

    // Offers one word, waits for its acceptance and records its result.
    task automatic send_word(input stim_row_t w);
        parse_result_t res;
        logic          got;
        while ($urandom_range(99) < gap_pct) begin
            word_in.valid <= 1'b0;
            @(posedge i_clk);
        end
        word_in.valid       <= 1'b1;
        word_in.char_code   <= w.chr;
        word_in.end_of_text <= w.eot;
        @(posedge i_clk);
        while (!word_in.ready) @(posedge i_clk);
        words_sent++;
        got = parse_word(w.chr, w.eot, res);
        if (w.typed) begin
            got        = w.has_res;
            res.status = w.status;
            res.value  = w.value;
        end
        if (got) begin
            pending_results.push_back(res);
        end
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic drain_results();
        word_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // Result checking and receiver back-pressure.
    always @(posedge i_clk) begin : result_check
        parse_result_t want;
        if (result_out.valid && result_out.ready) begin
            if (pending_results.size() == 0) begin
                error_count++;
                $display("%0t: unexpected word: expected none, got status %0d value %0d",
                         $time, result_out.status, result_out.value);
            end else begin
                want = pending_results.pop_front();
                if (result_out.status !== want.status) begin
                    error_count++;
                    $display("%0t: status mismatch: expected %0d, got %0d",
                             $time, want.status, result_out.status);
                end
                if (result_out.value !== want.value) begin
                    error_count++;
                    $display("%0t: value mismatch: expected %0d, got %0d",
                             $time, want.value, result_out.value);
                end
            end
        end
        result_out.ready <= ($urandom_range(99) >= stall_pct);
    end

    // Stimulus: reset, the directed table, then random phases.
    initial begin : stimulus
        int goal;
        word_in.valid       = 1'b0;
        word_in.char_code   = 8'd0;
        word_in.end_of_text = 1'b0;
        result_out.ready    = 1'b0;
        i_rst_n             = 1'b0;
        tok_phase           = P_SKIP;
        tok_negative        = 1'b0;
        tok_radix           = RADIX_DEC;
        tok_magnitude       = 64'd0;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (DIRECTED[i]) begin
            send_word(DIRECTED[i]);
        end
        drain_results();

        for (int p = 0; p < 4; p++) begin
            gap_pct   = GAP_PCT[p];
            stall_pct = STALL_PCT[p];
            goal      = words_sent + WORDS_PER_PHASE;
            while (words_sent < goal) begin
                build_token();
                while (text_q.size() != 0) send_word(text_q.pop_front());
            end
            drain_results();
        end

        // Allow for the pipeline before the verdict.
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Watchdog well beyond the slowest correct run.
    initial begin : watchdog
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== signed_radix_integer_parser.f =====
hw/rtl/srip_pkg.sv
hw/rtl/srip_in_if.sv
hw/rtl/srip_out_if.sv
hw/rtl/srip_char_class.sv
hw/rtl/srip_accum.sv
hw/rtl/signed_radix_integer_parser.sv
dv/signed_radix_integer_parser_test.sv
